FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sla_pkg.sv
// Shared constants and types for the sensor linearise-and-average block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sla_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int HISTORY_MAX_DEF = 8;

  localparam int RAW_W  = 16;
  localparam int REAL_W = 16;
  localparam int IDX_W  = 5;
  localparam int CFG_W  = 4;
  localparam int PROD_W = 32;

  localparam logic [RAW_W-1:0] END_KEY = 16'hffff;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_LOAD   = 1'b1
  } req_type_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sla_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on sla_pkg for field widths and the request type.
`timescale 1ns / 1ps
`default_nettype none

interface sla_in_if;
  import sla_pkg::*;

  logic                     valid;
  logic                     ready;
  req_type_t                req_type;
  logic [RAW_W-1:0]         sample_value;
  logic [IDX_W-1:0]         entry_index;
  logic [RAW_W-1:0]         entry_raw;
  logic signed [REAL_W-1:0] entry_real;

  modport source (
    output valid, req_type, sample_value, entry_index, entry_raw, entry_real,
    input  ready
  );
  modport sink (
    input  valid, req_type, sample_value, entry_index, entry_raw, entry_real,
    output ready
  );
endinterface

interface sla_out_if;
  import sla_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [REAL_W-1:0] converted_value;
  logic [RAW_W-1:0]         raw_average;
  logic signed [REAL_W-1:0] converted_average;

  modport source (
    output valid, converted_value, raw_average, converted_average,
    input  ready
  );
  modport sink (
    input  valid, converted_value, raw_average, converted_average,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/sla_div.sv
// Unsigned restoring divider retiring one quotient bit per cycle.
// No dependencies; instantiated by the top level for interpolation and averaging.
`timescale 1ns / 1ps
`default_nettype none

module sla_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quo,
  output logic [DEN_W-1:0]      rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NUM_W);
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sensor_linearize_and_average.sv
// Sensor linearisation through a calibration table, with moving averages.
// Depends on sla_pkg, sla_if.sv, sla_div.sv and assert_macros.svh.
//
// Input channel in_chan carries load items (write one table slot) and sample
// items. A load item gives no result. A sample item
// gives one result on out_chan: the converted value and the averages of the
// raw and converted histories over history_length slots.
// The table and both histories live in synchronous memories. A sample first
// walks the table one slot per cycle, then, if it falls between two keys, runs
// a serial division for the interpolation, then updates the running sums and
// runs the two averaging divisions together. out_chan.valid rises once both
// divisions are done and the output register is free; no further item is
// taken until then, so one sample is in flight at a time.
// Writing cfg_wdata with cfg_we clears both histories and the ring position.
// Synchronous reset empties the table (every slot reads as the end marker),
// clears the histories and sets history_length to 1; no clearing pass is needed.
// A result waits in the output register while out_chan is stalled; load items are
// still taken, and one further sample is taken and held until the register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sensor_linearize_and_average #(
  parameter int TABLE_DEPTH = sla_pkg::TABLE_DEPTH_DEF,
  parameter int HISTORY_MAX = sla_pkg::HISTORY_MAX_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [sla_pkg::CFG_W-1:0] cfg_wdata,
  sla_in_if.sink                         in_chan,
  sla_out_if.source                      out_chan
);
  import sla_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int HL_W  = $clog2(HISTORY_MAX + 1);
  localparam int PW    = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
  localparam int MAG_W = RAW_W + $clog2(HISTORY_MAX);
  localparam int CS_W  = MAG_W + 1;

  typedef struct packed {
    logic [RAW_W-1:0]         key;
    logic signed [REAL_W-1:0] val;
  } tbl_entry_t;

  typedef struct packed {
    logic [RAW_W-1:0]         raw;
    logic signed [REAL_W-1:0] conv;
  } ring_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_RING,
    S_AVG
  } state_t;

  tbl_entry_t  tbl_mem [TABLE_DEPTH];
  ring_entry_t ring_mem [HISTORY_MAX];

  state_t                   state_r;
  logic [TABLE_DEPTH-1:0]   tbl_vld_r;
  logic [HISTORY_MAX-1:0]   ring_vld_r;
  logic [HL_W-1:0]          hl_r;
  logic [PW-1:0]            pos_r;
  logic [MAG_W-1:0]         raw_sum_r;
  logic signed [CS_W-1:0]   conv_sum_r;
  tbl_entry_t               tbl_q_r;
  logic                     tbl_vld_q_r;
  ring_entry_t              ring_q_r;
  logic                     ring_old_vld_r;
  logic [RAW_W-1:0]         x_r;
  logic [AW-1:0]            slot_r;
  logic [RAW_W-1:0]         prev_key_r;
  logic signed [REAL_W-1:0] prev_val_r;
  logic [RAW_W-1:0]         dmag_r;
  logic                     neg_r;
  logic [RAW_W-1:0]         dx_r;
  logic [RAW_W-1:0]         draw_r;
  logic signed [REAL_W-1:0] conv_r;
  logic                     conv_neg_r;
  logic                     out_valid_r;
  logic signed [REAL_W-1:0] out_conv_r;
  logic [RAW_W-1:0]         out_raw_avg_r;
  logic signed [REAL_W-1:0] out_conv_avg_r;

  logic                     in_acc;
  logic                     is_load;
  logic                     idx_ok;
  logic                     out_free;
  logic                     res_load;
  logic                     tbl_rd_en;
  logic [AW-1:0]            tbl_rd_addr;
  logic [RAW_W-1:0]         key_cur;
  logic signed [REAL_W-1:0] val_cur;
  logic                     hit_end;
  logic                     hit_eq;
  logic                     at_last;
  logic                     hit_between;
  logic                     advance;
  logic signed [REAL_W:0]   dreal;
  logic signed [17:0]       q_s;
  logic signed [17:0]       adj_s;
  logic signed [17:0]       interp_s;
  logic [RAW_W-1:0]         old_raw;
  logic signed [REAL_W-1:0] old_conv;
  logic [MAG_W-1:0]         raw_sum_nxt;
  logic signed [CS_W-1:0]   conv_sum_nxt;
  logic [MAG_W-1:0]         conv_mag_nxt;
  logic [HL_W-1:0]          hl_nxt;
  logic                     div_a_start;
  logic [PROD_W-1:0]        div_a_num;
  logic [RAW_W-1:0]         div_a_den;
  logic                     div_a_busy;
  logic [PROD_W-1:0]        div_a_quo;
  logic [RAW_W-1:0]         div_a_rem;
  logic                     div_b_busy;
  logic [MAG_W-1:0]         div_b_quo;
  logic [HL_W-1:0]          div_b_rem;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_load       = (in_chan.req_type == REQ_LOAD);
  assign idx_ok        = 32'(in_chan.entry_index) < TABLE_DEPTH;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign res_load      = (state_r == S_AVG) && !div_a_busy && !div_b_busy && out_free;

  assign key_cur = tbl_vld_q_r ? tbl_q_r.key : END_KEY;
  assign val_cur = tbl_vld_q_r ? tbl_q_r.val : '0;

  assign hit_end     = (prev_key_r == END_KEY);
  assign hit_eq      = (prev_key_r == x_r);
  assign at_last     = (32'(slot_r) == TABLE_DEPTH - 1);
  assign hit_between = (prev_key_r < x_r) && (key_cur > x_r);
  assign advance     = !(hit_end || hit_eq || at_last || hit_between);
  assign dreal       = $signed({val_cur[REAL_W-1], val_cur})
                     - $signed({prev_val_r[REAL_W-1], prev_val_r});

  always_comb begin
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        tbl_rd_en = in_acc && !is_load;
      end
      S_FIRST: begin
        tbl_rd_en   = 1'b1;
        tbl_rd_addr = AW'(1);
      end
      S_SCAN: begin
        tbl_rd_en   = advance && (32'(slot_r) + 2 < TABLE_DEPTH);
        tbl_rd_addr = AW'(32'(slot_r) + 2);
      end
      default: begin
        tbl_rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_load && idx_ok) begin
      tbl_mem[AW'(in_chan.entry_index)] <= '{key: in_chan.entry_raw, val: in_chan.entry_real};
    end
    if (tbl_rd_en) begin
      tbl_q_r     <= tbl_mem[tbl_rd_addr];
      tbl_vld_q_r <= tbl_vld_r[tbl_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RING) begin
      ring_mem[pos_r] <= '{raw: x_r, conv: conv_r};
    end
    if (in_acc && !is_load) begin
      ring_q_r <= ring_mem[pos_r];
    end
  end

  // Floor division of a signed product: the divider works on magnitudes.
  assign q_s      = $signed({1'b0, div_a_quo[16:0]});
  assign adj_s    = neg_r ? ((div_a_rem != '0) ? -q_s - 18'sd1 : -q_s) : q_s;
  assign interp_s = $signed({{2{prev_val_r[REAL_W-1]}}, prev_val_r}) + adj_s;

  assign old_raw      = ring_old_vld_r ? ring_q_r.raw : '0;
  assign old_conv     = ring_old_vld_r ? ring_q_r.conv : '0;
  assign raw_sum_nxt  = raw_sum_r + MAG_W'(x_r) - MAG_W'(old_raw);
  assign conv_sum_nxt = conv_sum_r + CS_W'(conv_r) - CS_W'(old_conv);
  assign conv_mag_nxt = MAG_W'(conv_sum_nxt[CS_W-1] ? -conv_sum_nxt : conv_sum_nxt);

  always_comb begin
    if (cfg_wdata == '0) begin
      hl_nxt = HL_W'(1);
    end else if (32'(cfg_wdata) > HISTORY_MAX) begin
      hl_nxt = HL_W'(HISTORY_MAX);
    end else begin
      hl_nxt = HL_W'(cfg_wdata);
    end
  end

  assign div_a_start = (state_r == S_MUL) || (state_r == S_RING);
  assign div_a_num   = (state_r == S_MUL) ? 32'(dmag_r) * 32'(dx_r) : PROD_W'(raw_sum_nxt);
  assign div_a_den   = (state_r == S_MUL) ? draw_r : RAW_W'(hl_r);

  sla_div #(
    .NUM_W (PROD_W),
    .DEN_W (RAW_W)
  ) u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_a_start),
    .num   (div_a_num),
    .den   (div_a_den),
    .busy  (div_a_busy),
    .quo   (div_a_quo),
    .rem   (div_a_rem)
  );

  sla_div #(
    .NUM_W (MAG_W),
    .DEN_W (HL_W)
  ) u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_RING),
    .num   (conv_mag_nxt),
    .den   (hl_r),
    .busy  (div_b_busy),
    .quo   (div_b_quo),
    .rem   (div_b_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tbl_vld_r   <= '0;
      ring_vld_r  <= '0;
      hl_r        <= HL_W'(1);
      pos_r       <= '0;
      raw_sum_r   <= '0;
      conv_sum_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready && !res_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (is_load) begin
              if (idx_ok) begin
                tbl_vld_r[AW'(in_chan.entry_index)] <= 1'b1;
              end
            end else begin
              x_r            <= in_chan.sample_value;
              ring_old_vld_r <= ring_vld_r[pos_r];
              state_r        <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          prev_key_r <= key_cur;
          prev_val_r <= val_cur;
          slot_r     <= '0;
          state_r    <= S_SCAN;
        end
        S_SCAN: begin
          if (hit_end || at_last) begin
            conv_r  <= hit_eq && !hit_end ? prev_val_r : '0;
            state_r <= S_RING;
          end else if (hit_eq) begin
            conv_r  <= prev_val_r;
            state_r <= S_RING;
          end else if (hit_between) begin
            dmag_r  <= RAW_W'(dreal[REAL_W] ? -dreal : dreal);
            neg_r   <= dreal[REAL_W];
            dx_r    <= x_r - prev_key_r;
            draw_r  <= key_cur - prev_key_r;
            state_r <= S_MUL;
          end else begin
            prev_key_r <= key_cur;
            prev_val_r <= val_cur;
            slot_r     <= slot_r + AW'(1);
          end
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!div_a_busy) begin
            conv_r  <= interp_s[REAL_W-1:0];
            state_r <= S_RING;
          end
        end
        S_RING: begin
          raw_sum_r         <= raw_sum_nxt;
          conv_sum_r        <= conv_sum_nxt;
          conv_neg_r        <= conv_sum_nxt[CS_W-1];
          ring_vld_r[pos_r] <= 1'b1;
          if (32'(pos_r) + 1 >= 32'(hl_r)) begin
            pos_r <= '0;
          end else begin
            pos_r <= pos_r + PW'(1);
          end
          state_r <= S_AVG;
        end
        S_AVG: begin
          if (res_load) begin
            out_valid_r    <= 1'b1;
            out_conv_r     <= conv_r;
            out_raw_avg_r  <= div_a_quo[RAW_W-1:0];
            out_conv_avg_r <= REAL_W'(conv_neg_r ? (~div_b_quo + MAG_W'(1)) : div_b_quo);
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        hl_r       <= hl_nxt;
        pos_r      <= '0;
        ring_vld_r <= '0;
        raw_sum_r  <= '0;
        conv_sum_r <= '0;
      end
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.converted_value   = out_conv_r;
  assign out_chan.raw_average       = out_raw_avg_r;
  assign out_chan.converted_average = out_conv_avg_r;

  `SLA_ASSERT_IMPL(a_idle_div_quiet, state_r == S_IDLE, !div_a_busy && !div_b_busy)
  `SLA_ASSERT_IMPL(a_pos_in_ring, 1'b1, 32'(pos_r) < 32'(hl_r))
  `SLA_ASSERT_NEXT(a_result_loaded,
                   state_r == S_AVG && !div_a_busy && !div_b_busy && out_free,
                   out_valid_r && state_r == S_IDLE)
  `SLA_ASSERT_NEXT(a_cfg_clears, cfg_we, ring_vld_r == '0 && raw_sum_r == '0)

endmodule

`default_nettype wire
